>>> rtl/core/triac_phase_angle_dimmer_unit_assert.svh
// assertion macros for the triac dimmer
// used by triac_phase_angle_dimmer_unit; expects a clk and rst in scope
`ifndef TRIAC_PHASE_ANGLE_DIMMER_UNIT_ASSERT_SVH
`define TRIAC_PHASE_ANGLE_DIMMER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define TPAD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tpad assertion failed");
`define TPAD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tpad assertion failed");
`else
`define TPAD_ASSERT(lbl, prop)
`define TPAD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/core/tpad_pkg.sv
// types, constants and channel helpers for the triac dimmer
// no dependencies
package tpad_pkg;

  localparam int LEVEL_W   = 8;
  localparam int HALF_W    = 8;
  localparam int FIFTY_W   = 10;
  localparam int WATCH_W   = 16;
  localparam int TICKS_W   = 18;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 4;
  localparam int IN_DW     = 24;
  localparam int OUT_DW    = 8;

  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = 8'd100;
  localparam logic [HALF_W-1:0]  CAL_HALF_RST  = 8'd10;
  localparam logic [FIFTY_W-1:0] FIFTY_RST     = 10'd183;
  localparam logic [WATCH_W-1:0] TIMEOUT_RST   = 16'd400;

  typedef enum logic [1:0] {
    FUNC_CROSS = 2'd0,
    FUNC_FAST  = 2'd1,
    FUNC_PHASE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_MAX_LEVEL = 2'd0,
    REG_CAL_HALF  = 2'd1,
    REG_FIFTY     = 2'd2,
    REG_TIMEOUT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] delay;
    logic               fired;
    logic               gate;
  } chan_t;

  typedef struct packed {
    logic               freq_done;
    logic               measuring;
    logic               is_fifty;
    logic [HALF_W-1:0]  half_left;
    logic [TICKS_W-1:0] ticks;
    logic [WATCH_W-1:0] watch;
    logic               ac_error;
    logic               ac_good;
    logic               fault;
    chan_t              ch_one;
    chan_t              ch_two;
    logic               phase_run;
  } state_t;

  function automatic chan_t load_chan(logic [LEVEL_W-1:0] level,
                                      logic [LEVEL_W-1:0] max_lvl);
    chan_t              c;
    logic [LEVEL_W-1:0] lvl;
    lvl = (level > max_lvl) ? max_lvl : level;
    if (lvl == max_lvl) begin
      c.gate  = 1'b1;
      c.delay = '0;
      c.fired = 1'b1;
    end else begin
      c.delay = max_lvl - lvl;
      c.fired = 1'b0;
      c.gate  = 1'b0;
    end
    return c;
  endfunction

  function automatic chan_t count_chan(chan_t c_in);
    chan_t c;
    c = c_in;
    if (c.delay != '0) begin
      c.delay = c.delay - 1'b1;
    end
    if (c.delay == '0 && !c.fired) begin
      c.gate  = 1'b1;
      c.fired = 1'b1;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/triac_phase_angle_dimmer_unit.sv
// Two-channel triac phase-angle dimmer with mains frequency detection and a
// mains watchdog. Every request is one event (zero cross, fast tick or phase
// tick) or, for the unused kind, no event, and yields exactly one status
// word. One request is taken per clock while the status is not stalled; a
// request passes an input register, the event and supervision logic (longest
// path: 10x8 threshold multiply, 18-bit compare) and the result register; a
// stalled status holds the request in the input register. Registers must
// be written over the APB port only while idle; the block does not check.
// depends on tpad_pkg and triac_phase_angle_dimmer_unit_assert.svh
`include "triac_phase_angle_dimmer_unit_assert.svh"

module triac_phase_angle_dimmer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cross_pin_low, level_one, level_two
  input  logic [tpad_pkg::IN_DW-1:0]    s_tdata,
  // func
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // lamp_one_on, lamp_two_on, phase_timer_on, freq_known, mains_is_50hz,
  // mains_ok, mains_fault
  output logic [tpad_pkg::OUT_DW-1:0]   m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpad_pkg::APB_AW-1:0]   paddr,
  input  logic [tpad_pkg::APB_DW-1:0]   pwdata,
  output logic [tpad_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  logic [tpad_pkg::LEVEL_W-1:0] max_level;
  logic [tpad_pkg::HALF_W-1:0]  cal_half;
  logic [tpad_pkg::FIFTY_W-1:0] fifty_ticks;
  logic [tpad_pkg::WATCH_W-1:0] timeout;

  logic                          in_valid;
  tpad_pkg::func_t               in_func;
  logic                          in_pin_low;
  logic [tpad_pkg::LEVEL_W-1:0]  in_level_one;
  logic [tpad_pkg::LEVEL_W-1:0]  in_level_two;

  tpad_pkg::state_t              st;
  tpad_pkg::state_t              st_next;
  logic [tpad_pkg::TICKS_W-1:0]  thresh;
  logic                          advance;
  logic                          cfg_wr;
  tpad_pkg::reg_idx_t            cfg_idx;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = tpad_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level   <= tpad_pkg::MAX_LEVEL_RST;
      cal_half    <= tpad_pkg::CAL_HALF_RST;
      fifty_ticks <= tpad_pkg::FIFTY_RST;
      timeout     <= tpad_pkg::TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tpad_pkg::REG_MAX_LEVEL: max_level   <= pwdata[tpad_pkg::LEVEL_W-1:0];
        tpad_pkg::REG_CAL_HALF:  cal_half    <= pwdata[tpad_pkg::HALF_W-1:0];
        tpad_pkg::REG_FIFTY:     fifty_ticks <= pwdata[tpad_pkg::FIFTY_W-1:0];
        tpad_pkg::REG_TIMEOUT:   timeout     <= pwdata[tpad_pkg::WATCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tpad_pkg::REG_MAX_LEVEL: prdata = tpad_pkg::APB_DW'(max_level);
      tpad_pkg::REG_CAL_HALF:  prdata = tpad_pkg::APB_DW'(cal_half);
      tpad_pkg::REG_FIFTY:     prdata = tpad_pkg::APB_DW'(fifty_ticks);
      tpad_pkg::REG_TIMEOUT:   prdata = tpad_pkg::APB_DW'(timeout);
      default:                 prdata = '0;
    endcase
  end

  // input register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func      <= tpad_pkg::func_t'(s_tuser);
      in_pin_low   <= s_tdata[0];
      in_level_one <= s_tdata[8:1];
      in_level_two <= s_tdata[16:9];
    end
  end

  // event and supervision logic
  assign thresh = tpad_pkg::TICKS_W'(fifty_ticks) * tpad_pkg::TICKS_W'(cal_half);

  always_comb begin
    st_next = st;
    unique case (in_func)
      tpad_pkg::FUNC_CROSS: begin
        if (in_pin_low) begin
          st_next.watch    = timeout;
          st_next.ac_error = 1'b0;
          if (!st.freq_done) begin
            if (!st.measuring) begin
              st_next.measuring = 1'b1;
              st_next.ticks     = '0;
              st_next.half_left = cal_half;
            end
            if (st_next.half_left == '0) begin
              st_next.is_fifty  = (st_next.ticks >= thresh);
              st_next.freq_done = 1'b1;
              st_next.measuring = 1'b0;
            end else begin
              st_next.half_left = st_next.half_left - 1'b1;
            end
          end else begin
            st_next.ch_one = tpad_pkg::load_chan(in_level_one, max_level);
            st_next.ch_two = tpad_pkg::load_chan(in_level_two, max_level);
            if (st_next.ch_one.delay != '0 || st_next.ch_two.delay != '0) begin
              st_next.phase_run = 1'b1;
            end
          end
        end
      end
      tpad_pkg::FUNC_FAST: begin
        if (st.measuring && st.ticks != '1) begin
          st_next.ticks = st.ticks + 1'b1;
        end
        if (st.watch != '0) begin
          st_next.watch = st.watch - 1'b1;
        end
      end
      tpad_pkg::FUNC_PHASE: begin
        if (st.phase_run) begin
          st_next.ch_one = tpad_pkg::count_chan(st.ch_one);
          st_next.ch_two = tpad_pkg::count_chan(st.ch_two);
          if (st_next.ch_one.delay == '0 && st_next.ch_two.delay == '0) begin
            st_next.phase_run = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // supervision
    if (st_next.watch == '0 && !st_next.ac_error) begin
      st_next.ac_error  = 1'b1;
      st_next.ac_good   = 1'b0;
      st_next.fault     = 1'b1;
      st_next.freq_done = 1'b0;
    end
    if (!st_next.freq_done && st_next.watch == '0) begin
      st_next.measuring = 1'b0;
      st_next.half_left = cal_half;
      st_next.ticks     = '0;
      st_next.watch     = timeout;
      st_next.fault     = 1'b1;
    end
    if (!st_next.ac_good && !st_next.ac_error && st_next.freq_done) begin
      st_next.ac_good = 1'b1;
      st_next.fault   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.freq_done <= 1'b0;
      st.measuring <= 1'b0;
      st.is_fifty  <= 1'b0;
      st.half_left <= tpad_pkg::CAL_HALF_RST;
      st.ticks     <= '0;
      st.watch     <= tpad_pkg::TIMEOUT_RST;
      st.ac_error  <= 1'b1;
      st.ac_good   <= 1'b0;
      st.fault     <= 1'b0;
      st.ch_one    <= '0;
      st.ch_two    <= '0;
      st.phase_run <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, st_next.fault, st_next.ac_good, st_next.is_fifty,
                  st_next.freq_done, st_next.phase_run, st_next.ch_two.gate,
                  st_next.ch_one.gate};
    end
  end

  `TPAD_ASSERT(a_good_not_fault, !(st.ac_good && st.fault))
  `TPAD_ASSERT(a_good_needs_freq, st.ac_good |-> st.freq_done)
  `TPAD_ASSERT(a_done_not_measuring, st.freq_done |-> !st.measuring)
  `TPAD_ASSERT(a_request_held, (s_tvalid && s_tready) |=> in_valid)
  `TPAD_ASSERT_ALWAYS(a_reset_idle, rst |=> (!in_valid && !m_tvalid))

endmodule

>>> test/dimmer_monitor.sv
// passive monitor for the two-channel triac dimmer: follows register writes
// and accepted events, predicts each status word and compares it
// depends on tpad_pkg
module dimmer_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // cross_pin_low, level_one, level_two
  input  logic [tpad_pkg::IN_DW-1:0]  s_tdata,
  // func
  input  logic [1:0]                  s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // lamp_one_on, lamp_two_on, phase_timer_on, freq_known, mains_is_50hz,
  // mains_ok, mains_fault
  input  logic [tpad_pkg::OUT_DW-1:0] m_tdata,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tpad_pkg::APB_AW-1:0] paddr,
  input  logic [tpad_pkg::APB_DW-1:0] pwdata,
  output int                          failures,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tpad_pkg::*;

  logic [LEVEL_W-1:0] max_lvl;
  logic [HALF_W-1:0]  cal_half;
  logic [FIFTY_W-1:0] fifty_thr;
  logic [WATCH_W-1:0] timeout;

  logic               freq_done, measuring, is_fifty, ac_error, ac_good, fault;
  logic [HALF_W-1:0]  half_left;
  logic [TICKS_W-1:0] ticks;
  logic [WATCH_W-1:0] watch;
  logic [LEVEL_W-1:0] dly_one, dly_two;
  logic               fired_one, fired_two, gate_one, gate_two, phase_run;

  logic [OUT_DW-1:0]  lamp_status_q[$];

  string field_names[8] = '{"lamp_one_on", "lamp_two_on", "phase_timer_on", "freq_known",
                            "mains_is_50hz", "mains_ok", "mains_fault", "pad"};

  task automatic arm_channel(input logic [LEVEL_W-1:0] level, inout logic [LEVEL_W-1:0] dly,
                             inout logic fired, inout logic gate);
    logic [LEVEL_W-1:0] lvl;
    lvl = (level > max_lvl) ? max_lvl : level;
    if (lvl == max_lvl) begin
      gate  = 1'b1;
      dly   = '0;
      fired = 1'b1;
    end else begin
      dly   = max_lvl - lvl;
      fired = 1'b0;
      gate  = 1'b0;
    end
  endtask

  task automatic count_channel(inout logic [LEVEL_W-1:0] dly, inout logic fired,
                               inout logic gate);
    if (dly != '0) dly = dly - 1'b1;
    if (dly == '0 && !fired) begin
      gate  = 1'b1;
      fired = 1'b1;
    end
  endtask

  task automatic advance_dimmer(input func_t kind, input logic pin,
                                input logic [LEVEL_W-1:0] lvl_a, input logic [LEVEL_W-1:0] lvl_b,
                                output logic [OUT_DW-1:0] status);
    case (kind)
      FUNC_CROSS: if (pin) begin
        watch    = timeout;
        ac_error = 1'b0;
        if (!freq_done) begin
          if (!measuring) begin
            measuring = 1'b1;
            ticks     = '0;
            half_left = cal_half;
          end
          if (half_left == '0) begin
            is_fifty  = int'(ticks) >= int'(fifty_thr) * int'(cal_half);
            freq_done = 1'b1;
            measuring = 1'b0;
          end else begin
            half_left = half_left - 1'b1;
          end
        end else begin
          arm_channel(lvl_a, dly_one, fired_one, gate_one);
          arm_channel(lvl_b, dly_two, fired_two, gate_two);
          if (dly_one != '0 || dly_two != '0) phase_run = 1'b1;
        end
      end
      FUNC_FAST: begin
        if (measuring && ticks != {TICKS_W{1'b1}}) ticks = ticks + 1'b1;
        if (watch != '0) watch = watch - 1'b1;
      end
      FUNC_PHASE: if (phase_run) begin
        count_channel(dly_one, fired_one, gate_one);
        count_channel(dly_two, fired_two, gate_two);
        if (dly_one == '0 && dly_two == '0) phase_run = 1'b0;
      end
      default: ;
    endcase

    // mains watchdog and measurement restart
    if (watch == '0 && !ac_error) begin
      ac_error  = 1'b1;
      ac_good   = 1'b0;
      fault     = 1'b1;
      freq_done = 1'b0;
    end
    if (!freq_done && watch == '0) begin
      measuring = 1'b0;
      half_left = cal_half;
      ticks     = '0;
      watch     = timeout;
      fault     = 1'b1;
    end
    if (!ac_good && !ac_error && freq_done) begin
      ac_good = 1'b1;
      fault   = 1'b0;
    end

    status = {1'b0, fault, ac_good, is_fifty, freq_done, phase_run, gate_two, gate_one};
  endtask

  always @(posedge clk) begin
    logic [OUT_DW-1:0] want;
    logic              field_bad;
    if (rst) begin
      failures  = 0;
      max_lvl   = MAX_LEVEL_RST;
      cal_half  = CAL_HALF_RST;
      fifty_thr = FIFTY_RST;
      timeout   = TIMEOUT_RST;
      freq_done = 1'b0;
      measuring = 1'b0;
      is_fifty  = 1'b0;
      half_left = CAL_HALF_RST;
      ticks     = '0;
      watch     = TIMEOUT_RST;
      ac_error  = 1'b1;
      ac_good   = 1'b0;
      fault     = 1'b0;
      dly_one   = '0;
      dly_two   = '0;
      fired_one = 1'b0;
      fired_two = 1'b0;
      gate_one  = 1'b0;
      gate_two  = 1'b0;
      phase_run = 1'b0;
      lamp_status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MAX_LEVEL: max_lvl   = pwdata[LEVEL_W-1:0];
          REG_CAL_HALF:  cal_half  = pwdata[HALF_W-1:0];
          REG_FIFTY:     fifty_thr = pwdata[FIFTY_W-1:0];
          REG_TIMEOUT:   timeout   = pwdata[WATCH_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        advance_dimmer(func_t'(s_tuser), s_tdata[0], s_tdata[8:1], s_tdata[16:9], want);
        lamp_status_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (lamp_status_q.size() == 0) begin
          $display("%0t: unexpected status expected none got %b", $time, m_tdata);
          failures = failures + 1;
        end else begin
          want      = lamp_status_q.pop_front();
          field_bad = 1'b0;
          for (int i = 0; i < OUT_DW; i++) begin
            if (m_tdata[i] !== want[i]) begin
              field_bad = 1'b1;
              $display("%0t: %s expected %0b got %0b", $time, field_names[i], want[i],
                       m_tdata[i]);
            end
          end
          if (field_bad) failures = failures + 1;
        end
      end
    end
    pending <= lamp_status_q.size();
  end

endmodule

>>> test/tb.sv
// top of the triac dimmer testbench: clock, reset, event and register stimulus
// with random idling on both streams, and the final verdict
// depends on tpad_pkg, triac_phase_angle_dimmer_unit and dimmer_monitor
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tpad_pkg::*;

  localparam int LIMIT = 2000000;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_DW-1:0]    s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DW-1:0]   m_tdata;
  logic                psel, penable, pwrite, pready;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  int                  failures, pending;

  logic                idle_on = 1'b1;
  int                  stall_left = 0;
  int                  cycle_count = 0;
  int                  sent = 0;
  logic [LEVEL_W-1:0]  cfg_max = MAX_LEVEL_RST;
  logic [HALF_W-1:0]   cfg_cal = CAL_HALF_RST;
  logic [FIFTY_W-1:0]  cfg_thr = FIFTY_RST;
  logic [WATCH_W-1:0]  cfg_tmo = TIMEOUT_RST;

  triac_phase_angle_dimmer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  dimmer_monitor mon (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .failures(failures), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 12);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_event(input func_t kind, input logic pin,
                            input logic [LEVEL_W-1:0] lvl_a, input logic [LEVEL_W-1:0] lvl_b);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {7'b0, lvl_b, lvl_a, pin};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent = sent + 1;
  endtask

  task automatic write_settings(input logic [LEVEL_W-1:0] mx, input logic [HALF_W-1:0] cal,
                                input logic [FIFTY_W-1:0] thr, input logic [WATCH_W-1:0] tmo);
    logic [APB_DW-1:0] vals[4];
    int                reg_bits[4];
    logic [APB_DW-1:0] junk, mask;
    vals     = '{APB_DW'(mx), APB_DW'(cal), APB_DW'(thr), APB_DW'(tmo)};
    reg_bits = '{LEVEL_W, HALF_W, FIFTY_W, WATCH_W};
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    for (int i = 0; i < 4; i++) begin
      junk = $urandom();
      mask = (32'h1 << reg_bits[i]) - 1;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(i), 2'b00};
      pwdata  <= (junk & ~mask) | (vals[i] & mask);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_max = mx;
    cfg_cal = cal;
    cfg_thr = thr;
    cfg_tmo = tmo;
  endtask

  function automatic logic [LEVEL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return '0;
    if (r < 45) return cfg_max;
    if (r < 60) return (cfg_max == 8'hff) ? 8'hff : 8'($urandom_range(cfg_max + 1, 255));
    return 8'($urandom_range(0, cfg_max));
  endfunction

  task automatic send_noise();
    send_event(func_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // one mains half-cycle: a zero cross, then fast, phase and noise events mixed
  task automatic drive_half_cycle();
    int base, nfast, nphase;
    send_event(FUNC_CROSS, 1'b1, pick_level(), pick_level());
    base = cfg_thr;
    if (base > 40) base = $urandom_range(0, 40);
    nfast = $urandom_range(base > 2 ? base - 2 : 0, base + 2);
    if (cfg_tmo == 0) nfast = $urandom_range(0, 3);
    else if (cfg_tmo <= 64 && $urandom_range(0, 9) == 0) nfast = cfg_tmo + $urandom_range(0, 2);
    else if (nfast >= cfg_tmo) nfast = cfg_tmo - 1;
    nphase = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cfg_max + 2)
                                         : cfg_max + $urandom_range(0, 2);
    while (nfast + nphase > 0) begin
      if ($urandom_range(0, 19) == 0) begin
        send_noise();
      end else if (nphase == 0 || (nfast > 0 && $urandom_range(0, 1) == 1)) begin
        send_event(FUNC_FAST, 1'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()));
        nfast = nfast - 1;
      end else begin
        send_event(FUNC_PHASE, 1'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()));
        nphase = nphase - 1;
      end
    end
  endtask

  task automatic run_mains(input int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 80) drive_half_cycle();
      else send_noise();
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = FUNC_NONE;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unused kind, stopped phase tick, pin not low, fast tick
    send_event(FUNC_NONE, 1'b1, 8'hff, 8'h00);
    send_event(FUNC_PHASE, 1'b1, 8'h00, 8'hff);
    send_event(FUNC_CROSS, 1'b0, 8'hff, 8'hff);
    send_event(FUNC_FAST, 1'b0, 8'h00, 8'h00);

    write_settings(8'd4, 8'd1, 10'd2, 16'd6);
    send_event(FUNC_CROSS, 1'b1, 8'h00, 8'h00);
    repeat (2) send_event(FUNC_FAST, 1'b0, 8'h00, 8'h00);
    send_event(FUNC_CROSS, 1'b1, 8'h00, 8'h00);
    send_event(FUNC_CROSS, 1'b1, 8'hff, 8'h00);
    repeat (5) send_event(FUNC_PHASE, 1'b0, 8'h00, 8'h00);
    send_event(FUNC_CROSS, 1'b1, 8'h01, 8'h04);
    send_event(FUNC_FAST, 1'b1, 8'hff, 8'hff);
    repeat (3) send_event(FUNC_PHASE, 1'b1, 8'hff, 8'hff);
    send_event(FUNC_NONE, 1'b0, 8'h00, 8'h00);
    send_event(FUNC_CROSS, 1'b1, 8'h00, 8'h00);
    repeat (6) send_event(FUNC_FAST, 1'b0, 8'h00, 8'h00);
    send_event(FUNC_CROSS, 1'b0, 8'hff, 8'hff);

    write_settings(8'd8, 8'd3, 10'd4, 16'd24);
    run_mains(200);
    write_settings(8'd255, 8'd1, 10'd1023, 16'd65535);
    run_mains(250);
    write_settings(8'd0, 8'd0, 10'd0, 16'd0);
    run_mains(60);
    write_settings(8'd1, 8'd255, 10'd1, 16'd1);
    run_mains(40);

    // last part without idling
    idle_on <= 1'b0;
    write_settings(8'd12, 8'd2, 10'd5, 16'd40);
    run_mains(150);

    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tpad_pkg.sv
rtl/core/triac_phase_angle_dimmer_unit.sv
test/dimmer_monitor.sv
test/tb.sv
